// File: rtl/core/isml_pkg.sv
`default_nettype none

package isml_pkg;

    localparam int MAX_RANGES_DEF = 64;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] revision;
        logic [31:0] range_size;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [31:0] previous_revision;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WALK,
        S_FINISH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic prime;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic early_out;
        logic walk_done;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/isml_ctrl.sv
`default_nettype none

module isml_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  isml_pkg::sts_t      sts,
    output isml_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done
);
    import isml_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.check = 1'b1;
                cmd.prime = 1'b1;
                state_next = sts.early_out ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/isml_datapath.sv
`default_nettype none

module isml_datapath #(
    parameter int MAX_RANGES = isml_pkg::MAX_RANGES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  isml_pkg::in_t       item,
    input  isml_pkg::cmd_t      cmd,
    output isml_pkg::sts_t      sts,
    output isml_pkg::out_t      result
);
    import isml_pkg::*;

    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    // Two banks: the walk reads the live bank and writes the rebuilt table
    // into the other one, so an aborted add leaves the live bank untouched.
    logic [31:0] start_a [MAX_RANGES];
    logic [31:0] size_a  [MAX_RANGES];
    logic [31:0] start_b [MAX_RANGES];
    logic [31:0] size_b  [MAX_RANGES];

    logic [31:0] rd_start_a_reg, rd_size_a_reg, rd_start_b_reg, rd_size_b_reg;

    logic          bank_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] wr_reg;
    logic [IW-1:0] cur_reg;
    logic          is_add_reg;
    logic [31:0]   rev_reg;
    logic [32:0]   end_reg;
    logic [31:0]   size_in_reg;
    logic [31:0]   ns_reg;
    logic [32:0]   ne_reg;
    logic          merged_reg;
    logic          emitted_reg;
    logic          cand_found_reg;
    logic [31:0]   cand_start_reg;
    logic [1:0]    status_reg;

    logic [32:0]   in_end;
    logic [31:0]   rd_start, rd_size;
    logic [32:0]   rd_end;
    logic          below, after, stall;
    logic [IW-1:0] raddr;
    logic          we;
    logic [31:0]   wd_start, wd_size;
    logic          full;

    assign in_end   = {1'b0, item.revision} + {1'b0, item.range_size};
    assign rd_start = bank_reg ? rd_start_b_reg : rd_start_a_reg;
    assign rd_size  = bank_reg ? rd_size_b_reg  : rd_size_a_reg;
    assign rd_end   = {1'b0, rd_start} + {1'b0, rd_size};
    assign below    = rd_end < {1'b0, rev_reg};
    assign after    = {1'b0, rd_start} > end_reg;
    // A full table refuses the new range, so it is never emitted mid-walk.
    assign stall    = cmd.step && is_add_reg && after && !emitted_reg && !full;
    assign full     = (count_reg == CW'(MAX_RANGES)) && !merged_reg;

    assign sts.early_out = is_add_reg && ((size_in_reg == 32'd0) || end_reg[32]);
    assign sts.walk_done = (cnt_reg == count_reg);

    always_comb
    begin
        if (cmd.prime)
        begin
            raddr = '0;
        end
        else if (cmd.step && !stall)
        begin
            raddr = cur_reg + IW'(1);
        end
        else
        begin
            raddr = cur_reg;
        end
    end

    always_comb
    begin
        we       = 1'b0;
        wd_start = ns_reg;
        wd_size  = 32'(ne_reg - {1'b0, ns_reg});
        if (cmd.step && is_add_reg)
        begin
            if (stall)
            begin
                we = 1'b1;
            end
            else if (below || after)
            begin
                we       = 1'b1;
                wd_start = rd_start;
                wd_size  = rd_size;
            end
        end
        else if (cmd.finish && is_add_reg && !emitted_reg && !full)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && bank_reg)
        begin
            start_a[wr_reg[IW-1:0]] <= wd_start;
            size_a[wr_reg[IW-1:0]]  <= wd_size;
        end
        rd_start_a_reg <= start_a[raddr];
        rd_size_a_reg  <= size_a[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we && !bank_reg)
        begin
            start_b[wr_reg[IW-1:0]] <= wd_start;
            size_b[wr_reg[IW-1:0]]  <= wd_size;
        end
        rd_start_b_reg <= start_b[raddr];
        rd_size_b_reg  <= size_b[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg       <= 1'b0;
            count_reg      <= '0;
            cnt_reg        <= '0;
            wr_reg         <= '0;
            cur_reg        <= '0;
            is_add_reg     <= 1'b0;
            merged_reg     <= 1'b0;
            emitted_reg    <= 1'b0;
            cand_found_reg <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            cur_reg <= raddr;
            if (we)
            begin
                wr_reg <= wr_reg + CW'(1);
            end
            if (cmd.load)
            begin
                is_add_reg     <= (item.func == FUNC_ADD);
                cnt_reg        <= '0;
                wr_reg         <= '0;
                merged_reg     <= 1'b0;
                emitted_reg    <= 1'b0;
                cand_found_reg <= 1'b0;
            end
            if (cmd.check)
            begin
                if (!is_add_reg)
                begin
                    status_reg <= ST_OK;
                end
                else if (size_in_reg == 32'd0)
                begin
                    status_reg <= ST_EMPTY;
                end
                else if (end_reg[32])
                begin
                    status_reg <= ST_OVERFLOW;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            if (cmd.step)
            begin
                if (stall)
                begin
                    emitted_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (is_add_reg && !below && !after)
                begin
                    merged_reg <= 1'b1;
                end
                if (!is_add_reg && rd_start <= rev_reg)
                begin
                    cand_found_reg <= {1'b0, rev_reg} < rd_end;
                end
            end
            if (cmd.finish && is_add_reg)
            begin
                if (!emitted_reg && full)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    bank_reg  <= ~bank_reg;
                    count_reg <= wr_reg + CW'(!emitted_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rev_reg     <= item.revision;
            end_reg     <= in_end;
            size_in_reg <= item.range_size;
        end
        if (cmd.step)
        begin
            if (is_add_reg && !below && !after)
            begin
                ns_reg <= (rd_start < ns_reg) ? rd_start : ns_reg;
                ne_reg <= (rd_end > ne_reg) ? rd_end : ne_reg;
            end
            if (!is_add_reg && rd_start <= rev_reg)
            begin
                cand_start_reg <= rd_start;
            end
        end
        if (cmd.check)
        begin
            ns_reg <= rev_reg;
            ne_reg <= end_reg;
        end
    end

    assign result.found             = cand_found_reg;
    assign result.previous_revision = cand_found_reg ? (cand_start_reg - 32'd1) : 32'hFFFF_FFFF;
    assign result.status            = status_reg;
    assign result.entry_count       = 7'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RANGES))
        else $error("entry count exceeds table depth");

    a_single_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> !stall)
        else $error("merged range emitted twice");

    a_count_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(count_reg))
        else $error("entry count changed outside finish");

    a_add_never_found: assert property (@(posedge clk) disable iff (!rst_n)
        (is_add_reg && !cmd.load) |=> !cand_found_reg)
        else $error("add transaction reports a hit");

endmodule

`default_nettype wire

// File: rtl/core/interval_set_merge_and_gap_lookup_unit.sv
`default_nettype none
// An add or lookup walks the n stored ranges between start and done; an add that
// inserts ahead of a later entry pauses the walk once, and an empty or overflowing
// add skips the walk. One transaction at a time: busy holds off start meanwhile.
// The cost is set by the walk over the table, one entry read per cycle but for that pause.
// Reset clears the entry count; the result strobe cannot be stalled.

module interval_set_merge_and_gap_lookup_unit #(
    parameter int MAX_RANGES = isml_pkg::MAX_RANGES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  isml_pkg::in_t       item,
    output logic                busy,
    output logic                done,
    output isml_pkg::out_t      result
);
    import isml_pkg::*;

    cmd_t cmd;
    sts_t sts;

    isml_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    isml_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

`default_nettype wire
